### sv/nps_pkg.sv
`timescale 1ns / 1ps

package nps_pkg;

    // Width of the value, the candidate and the divisor.
    localparam int VALUE_WIDTH = 32;
    // Divider iteration counter: must hold VALUE_WIDTH itself.
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    typedef logic [VALUE_WIDTH-1:0] t_value;

    // Wheel steps: alternate 2 and 4; xor with 6 swaps them.
    localparam logic [2:0] STEP_TWO  = 3'd2;
    localparam logic [2:0] STEP_FOUR = 3'd4;
    localparam logic [2:0] STEP_SWAP = 3'd6;

    localparam t_value WHEEL_MOD     = t_value'(6);
    localparam t_value FIRST_DIVISOR = t_value'(5);

    typedef struct packed {
        logic   start;
        t_value dividend;
        t_value divisor;
    } t_div_req;

    typedef struct packed {
        logic   done;
        t_value quot;
        t_value rem;
    } t_div_rsp;

endpackage

### sv/nps_if.sv
`timescale 1ns / 1ps

interface nps_in_if;
    import nps_pkg::*;

    logic   valid;
    logic   ready;
    t_value start_value;

    modport source (output valid, output start_value, input ready);
    modport sink   (input valid, input start_value, output ready);
endinterface

interface nps_out_if;
    import nps_pkg::*;

    logic   valid;
    logic   ready;
    t_value prime_value;
    logic   overflow;

    modport source (output valid, output prime_value, output overflow, input ready);
    modport sink   (input valid, input prime_value, input overflow, output ready);
endinterface

### sv/nps_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module nps_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nps_pkg::t_div_req i_req,
    output nps_pkg::t_div_rsp o_rsp
);
    import nps_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_value           r_quot;
    t_value           r_rem;
    t_value           r_div;

    logic [VALUE_WIDTH:0] w_shift;
    logic [VALUE_WIDTH:0] w_diff;

    assign w_shift = {r_rem, r_quot[VALUE_WIDTH-1]};
    assign w_diff  = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(VALUE_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.dividend;
            r_rem  <= '0;
            r_div  <= i_req.divisor;
        end else if (r_busy) begin
            if (!w_diff[VALUE_WIDTH]) begin
                r_rem  <= w_diff[VALUE_WIDTH-1:0];
                r_quot <= {r_quot[VALUE_WIDTH-2:0], 1'b1};
            end else begin
                r_rem  <= w_shift[VALUE_WIDTH-1:0];
                r_quot <= {r_quot[VALUE_WIDTH-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider restarted while busy");

    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("divider busy with spent counter");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");

endmodule

### sv/next_prime_search.sv
`timescale 1ns / 1ps
// Start values 0 to 5 go straight to S_FIN and from there into the output register once it
//   is free. Larger values are first divided by six, then each candidate is trial divided
//   by successive wheel divisors, then the result passes through S_FIN to the output register.
// Only one transaction is handled at a time; the input is ready only in S_IDLE.
// Reset: synchronous, active low; clears the sequencer and the result valid flag.
// A new transaction is taken while a finished result still waits at the output.

module next_prime_search (
    input  logic             i_clk,
    input  logic             i_rst_n,
    nps_in_if.sink           i_in,
    nps_out_if.source        o_res
);
    import nps_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,   // waiting for a transaction
        S_WAIT6,  // dividing the start value by six
        S_ISSUE,  // launch trial division of candidate by divisor
        S_WAITT,  // waiting for the trial division
        S_FIN     // result ready, waiting for the output register
    } t_state;

    t_state   r_state;
    t_value   r_x;        // start value
    t_value   r_cand;     // candidate under test
    logic [2:0] r_cstep;  // next candidate step
    t_value   r_d;        // trial divisor
    logic [2:0] r_dstep;  // next divisor step
    t_value   r_result;
    logic     r_ovf;

    logic     r_ovalid;
    t_value   r_oprime;
    logic     r_oovf;

    t_div_req w_req;
    t_div_rsp w_rsp;
    logic     w_in_acc;
    logic     w_small;
    logic     w_out_free;

    logic [VALUE_WIDTH:0] w_first;  // base + offset, with carry for overflow
    logic [VALUE_WIDTH:0] w_next;   // candidate + step, with carry
    logic                 w_lo_res;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && (r_state == S_IDLE);
    assign w_small    = (i_in.start_value <= t_value'(5));
    assign w_out_free = !r_ovalid || o_res.ready;

    // The divider serves both the reduction modulo six and trial division.
    always_comb begin
        w_req.start    = (w_in_acc && !w_small) || (r_state == S_ISSUE);
        w_req.dividend = (r_state == S_IDLE) ? i_in.start_value : r_cand;
        w_req.divisor  = (r_state == S_IDLE) ? WHEEL_MOD : r_d;
    end

    nps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Remainder 0 or 1 -> 6k+1, then step 4; remainder 2..5 -> 6k+5, then step 2.
    assign w_lo_res = (w_rsp.rem < t_value'(2));
    assign w_first  = {1'b0, r_x - w_rsp.rem}
                    + (w_lo_res ? (VALUE_WIDTH+1)'(1) : (VALUE_WIDTH+1)'(5));
    assign w_next   = {1'b0, r_cand} + (VALUE_WIDTH+1)'(r_cstep);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            // in S_FIN the output register is either refilled or still held
            if (r_ovalid && o_res.ready && (r_state != S_FIN)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_x   <= i_in.start_value;
                        r_ovf <= 1'b0;
                        if (i_in.start_value <= t_value'(2)) begin
                            r_result <= t_value'(2);
                            r_state  <= S_FIN;
                        end else if (i_in.start_value == t_value'(3)) begin
                            r_result <= t_value'(3);
                            r_state  <= S_FIN;
                        end else if (w_small) begin
                            r_result <= t_value'(5);
                            r_state  <= S_FIN;
                        end else begin
                            r_state <= S_WAIT6;
                        end
                    end
                end
                S_WAIT6: begin
                    if (w_rsp.done) begin
                        if (w_first[VALUE_WIDTH]) begin
                            r_ovf    <= 1'b1;
                            r_result <= '0;
                            r_state  <= S_FIN;
                        end else begin
                            r_cand  <= w_first[VALUE_WIDTH-1:0];
                            r_cstep <= w_lo_res ? STEP_FOUR : STEP_TWO;
                            r_d     <= FIRST_DIVISOR;
                            r_dstep <= STEP_TWO;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_ISSUE: begin
                    r_state <= S_WAITT;
                end
                S_WAITT: begin
                    if (w_rsp.done) begin
                        if (w_rsp.quot < r_d) begin
                            // past the square root: prime
                            r_result <= r_cand;
                            r_state  <= S_FIN;
                        end else if (w_rsp.rem == '0) begin
                            // composite: move to the next wheel candidate
                            if (w_next[VALUE_WIDTH]) begin
                                r_ovf    <= 1'b1;
                                r_result <= '0;
                                r_state  <= S_FIN;
                            end else begin
                                r_cand  <= w_next[VALUE_WIDTH-1:0];
                                r_cstep <= r_cstep ^ STEP_SWAP;
                                r_d     <= FIRST_DIVISOR;
                                r_dstep <= STEP_TWO;
                                r_state <= S_ISSUE;
                            end
                        end else begin
                            r_d     <= r_d + t_value'(r_dstep);
                            r_dstep <= r_dstep ^ STEP_SWAP;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_oprime <= r_result;
                        r_oovf   <= r_ovf;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid       = r_ovalid;
    assign o_res.prime_value = r_oprime;
    assign o_res.overflow    = r_oovf;

    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken again before the search finished");

    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.overflow) |-> (o_res.prime_value == '0))
        else $error("overflow result not zero");

    a_odd_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.overflow)
            |-> (o_res.prime_value[0] || (o_res.prime_value == t_value'(2))))
        else $error("even result other than two");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE) |=> !w_rsp.done)
        else $error("divider done straight after launch");

endmodule
